// ===== rtl/core/imuc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register indexes, mode codes and helpers for the upright classifier.
// No dependencies; every module of the block refers to it by scoped names.
package imuc_pkg;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 136;
   localparam int unsigned RSP_DATA_W  = 88;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_PERIOD    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STATIONARY_RATE  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UPRIGHT_CROSS    = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_VALID_CROSS  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_VALID_CROSS  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ACCEL_NORM   = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_X_TILT_THRESHOLD = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_Z_UP_THRESHOLD   = 4'd7;

   // register reset values
   localparam logic [30:0] RST_SAMPLE_PERIOD    = 31'd100000;
   localparam logic [17:0] RST_STATIONARY_RATE  = 18'd200;
   localparam logic [15:0] RST_UPRIGHT_CROSS    = 16'd410;
   localparam logic [15:0] RST_MIN_VALID_CROSS  = 16'd820;
   localparam logic [15:0] RST_MAX_VALID_CROSS  = 16'd2458;
   localparam logic [15:0] RST_MAX_ACCEL_NORM   = 16'd3584;
   localparam logic [15:0] RST_X_TILT_THRESHOLD = 16'd1229;
   localparam logic [15:0] RST_Z_UP_THRESHOLD   = 16'd2028;

   localparam logic [31:0] SAFE_MIN_TIME_US = 32'd1000000;

   // squares are scaled down by 2048
   localparam int unsigned NORM_SHIFT = 11;

   // mode codes
   localparam logic [2:0] MODE_INIT        = 3'd0;
   localparam logic [2:0] MODE_SAFE        = 3'd1;
   localparam logic [2:0] MODE_UNKNOWN     = 3'd2;
   localparam logic [2:0] MODE_UPRIGHT     = 3'd3;
   localparam logic [2:0] MODE_NOT_UPRIGHT = 3'd4;

   typedef struct packed {
      logic [30:0] sample_period_us;
      logic [17:0] stationary_rate_limit;
      logic [15:0] upright_cross_limit;
      logic [15:0] min_valid_cross;
      logic [15:0] max_valid_cross;
      logic [15:0] max_accel_norm;
      logic [15:0] x_tilt_threshold;
      logic [15:0] z_up_threshold;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_us;
      logic        link_ok;
      logic        read_ok;
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
      logic [15:0] gyro_x;
      logic [15:0] gyro_y;
      logic [15:0] gyro_z;
   } item_type;

   typedef struct packed {
      logic [16:0] rate_sum;
      logic [20:0] accel_norm;
      logic [20:0] cross_norm;
      logic        still;
   } feat_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        orientation_known;
      logic [15:0] yaw_rate;
      logic        sample_taken;
      logic        read_failed;
      logic [16:0] rate_sum;
      logic [20:0] accel_norm;
      logic [20:0] cross_norm;
   } result_type;

   // sign-extend a 16-bit two's complement value for signed compares
   function automatic logic signed [21:0] ext22(input logic [15:0] v);
      return $signed({{6{v[15]}}, v});
   endfunction

   // magnitude of a 16-bit signed value; -32768 gives 32768
   function automatic logic [16:0] mag17(input logic [15:0] v);
      logic [16:0] e;
      e = {v[15], v};
      return v[15] ? (~e + 17'd1) : e;
   endfunction

endpackage

// ===== rtl/core/imuc_csr.sv =====
`timescale 1ns / 1ps
// Threshold and timing registers of the upright classifier.
// Depends on imuc_pkg for register indexes, reset values and cfg_type.
module imuc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [imuc_pkg::CSR_INDEX_W-1:0]   wr_index,
   input  logic [imuc_pkg::CSR_DATA_W-1:0]    wr_data,
   output imuc_pkg::cfg_type                  cfg
);

   imuc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            imuc_pkg::REG_SAMPLE_PERIOD:    cfg_in.sample_period_us      = wr_data[30:0];
            imuc_pkg::REG_STATIONARY_RATE:  cfg_in.stationary_rate_limit = wr_data[17:0];
            imuc_pkg::REG_UPRIGHT_CROSS:    cfg_in.upright_cross_limit   = wr_data[15:0];
            imuc_pkg::REG_MIN_VALID_CROSS:  cfg_in.min_valid_cross       = wr_data[15:0];
            imuc_pkg::REG_MAX_VALID_CROSS:  cfg_in.max_valid_cross       = wr_data[15:0];
            imuc_pkg::REG_MAX_ACCEL_NORM:   cfg_in.max_accel_norm        = wr_data[15:0];
            imuc_pkg::REG_X_TILT_THRESHOLD: cfg_in.x_tilt_threshold      = wr_data[15:0];
            imuc_pkg::REG_Z_UP_THRESHOLD:   cfg_in.z_up_threshold        = wr_data[15:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period_us      <= imuc_pkg::RST_SAMPLE_PERIOD;
         cfg_ff.stationary_rate_limit <= imuc_pkg::RST_STATIONARY_RATE;
         cfg_ff.upright_cross_limit   <= imuc_pkg::RST_UPRIGHT_CROSS;
         cfg_ff.min_valid_cross       <= imuc_pkg::RST_MIN_VALID_CROSS;
         cfg_ff.max_valid_cross       <= imuc_pkg::RST_MAX_VALID_CROSS;
         cfg_ff.max_accel_norm        <= imuc_pkg::RST_MAX_ACCEL_NORM;
         cfg_ff.x_tilt_threshold      <= imuc_pkg::RST_X_TILT_THRESHOLD;
         cfg_ff.z_up_threshold        <= imuc_pkg::RST_Z_UP_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/imuc_feature.sv =====
`timescale 1ns / 1ps
// Derived sample values: gyro magnitude sum, scaled accel norm, cross norm and still flag.
// Depends on imuc_pkg for item, feature and configuration types.
module imuc_feature (
   input  imuc_pkg::item_type  item,
   input  imuc_pkg::cfg_type   cfg,
   output imuc_pkg::feat_type  feat
);

   logic signed [31:0] sq_x, sq_y, sq_z;
   logic [19:0]        n_x, n_y, n_z;
   logic [16:0]        rate;
   logic [20:0]        norm;

   always_comb begin
      sq_x = $signed(item.accel_x) * $signed(item.accel_x);
      sq_y = $signed(item.accel_y) * $signed(item.accel_y);
      sq_z = $signed(item.accel_z) * $signed(item.accel_z);
      // squares are non-negative and below 2^31, so the shift is the divide
      n_x = sq_x[30:imuc_pkg::NORM_SHIFT];
      n_y = sq_y[30:imuc_pkg::NORM_SHIFT];
      n_z = sq_z[30:imuc_pkg::NORM_SHIFT];

      rate = imuc_pkg::mag17(item.gyro_x) + imuc_pkg::mag17(item.gyro_y)
           + imuc_pkg::mag17(item.gyro_z);
      norm = {1'b0, n_x} + {1'b0, n_y} + {1'b0, n_z};

      feat.rate_sum   = rate;
      feat.accel_norm = norm;
      feat.cross_norm = {1'b0, n_x} + {1'b0, n_y};
      feat.still      = ({1'b0, rate} < cfg.stationary_rate_limit)
                     && ($signed({1'b0, norm}) < imuc_pkg::ext22(cfg.max_accel_norm));
   end

endmodule

// ===== rtl/core/imuc_core.sv =====
`timescale 1ns / 1ps
// Mode machine and held sample state; forms one result per processed beat.
// Depends on imuc_pkg for types, mode codes and compare helpers.
module imuc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  imuc_pkg::item_type    item,
   input  imuc_pkg::feat_type    feat,
   input  imuc_pkg::cfg_type     cfg,
   output imuc_pkg::result_type  result
);

   typedef enum logic [2:0] {
      ST_INIT        = imuc_pkg::MODE_INIT,
      ST_SAFE        = imuc_pkg::MODE_SAFE,
      ST_UNKNOWN     = imuc_pkg::MODE_UNKNOWN,
      ST_UPRIGHT     = imuc_pkg::MODE_UPRIGHT,
      ST_NOT_UPRIGHT = imuc_pkg::MODE_NOT_UPRIGHT
   } mode_state_type;

   mode_state_type mode_ff, mode_in, mode_next, target;
   logic [31:0] start_ff, start_in, last_ff, last_in;
   logic        failed_ff, failed_in;
   logic [15:0] hax_ff, hax_in, haz_ff, haz_in, hgz_ff, hgz_in;
   logic [16:0] hrate_ff, hrate_in;
   logic [20:0] hnorm_ff, hnorm_in, hcross_ff, hcross_in;

   logic [31:0] mode_age, sample_age;
   logic        safe_done, take, stat, up, notup;
   logic signed [21:0] cross_s;

   always_comb begin
      // predicates on the values held from the last good sample
      cross_s = $signed({1'b0, hcross_ff});
      stat  = !failed_ff
           && ({1'b0, hrate_ff} < cfg.stationary_rate_limit)
           && ($signed({1'b0, hnorm_ff}) < imuc_pkg::ext22(cfg.max_accel_norm));
      up    = stat && (cross_s < imuc_pkg::ext22(cfg.upright_cross_limit))
           && (imuc_pkg::ext22(haz_ff) > imuc_pkg::ext22(cfg.z_up_threshold));
      notup = stat && !up
           && (cross_s > imuc_pkg::ext22(cfg.min_valid_cross))
           && (cross_s < imuc_pkg::ext22(cfg.max_valid_cross))
           && ($signed({5'b0, imuc_pkg::mag17(hax_ff)})
               > imuc_pkg::ext22(cfg.x_tilt_threshold));

      // settled mode: held values do not change while the mode settles,
      // so the chain of transitions collapses to one step
      target    = up ? ST_UPRIGHT : (notup ? ST_NOT_UPRIGHT : ST_UNKNOWN);
      mode_age  = item.now_us - start_ff;
      safe_done = mode_age > imuc_pkg::SAFE_MIN_TIME_US;
      mode_next = mode_ff;
      unique case (mode_ff) inside
         ST_INIT: mode_next = ST_SAFE;
         ST_SAFE: begin
            if (safe_done && item.link_ok) mode_next = target;
         end
         ST_UNKNOWN, ST_UPRIGHT, ST_NOT_UPRIGHT: begin
            mode_next = item.link_ok ? target : ST_SAFE;
         end
         default: mode_next = mode_ff;
      endcase

      sample_age = item.now_us - last_ff;
      take       = sample_age >= {1'b0, cfg.sample_period_us};

      mode_in   = mode_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      failed_in = failed_ff;
      hax_in    = hax_ff;
      haz_in    = haz_ff;
      hgz_in    = hgz_ff;
      hrate_in  = hrate_ff;
      hnorm_in  = hnorm_ff;
      hcross_in = hcross_ff;
      if (fire) begin
         mode_in = mode_next;
         if (mode_next != mode_ff) start_in = item.now_us;
         if (take) begin
            last_in = item.now_us;
            if (!item.read_ok) begin
               failed_in = 1'b1;
            end else begin
               failed_in = 1'b0;
               hax_in    = item.accel_x;
               haz_in    = item.accel_z;
               hgz_in    = item.gyro_z;
               hrate_in  = feat.rate_sum;
               hnorm_in  = feat.accel_norm;
               if (feat.still) hcross_in = feat.cross_norm;
            end
         end
      end

      result.mode              = mode_in;
      result.orientation_known = (mode_in == ST_UPRIGHT) || (mode_in == ST_NOT_UPRIGHT);
      result.yaw_rate          = failed_in ? 16'd0 : hgz_in;
      result.sample_taken      = take;
      result.read_failed       = failed_in;
      result.rate_sum          = hrate_in;
      result.accel_norm        = hnorm_in;
      result.cross_norm        = hcross_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ST_INIT;
         start_ff  <= '0;
         last_ff   <= '0;
         failed_ff <= 1'b0;
         hax_ff    <= '0;
         haz_ff    <= '0;
         hgz_ff    <= '0;
         hrate_ff  <= '0;
         hnorm_ff  <= '0;
         hcross_ff <= '0;
      end else begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         last_ff   <= last_in;
         failed_ff <= failed_in;
         hax_ff    <= hax_in;
         haz_ff    <= haz_in;
         hgz_ff    <= hgz_in;
         hrate_ff  <= hrate_in;
         hnorm_ff  <= hnorm_in;
         hcross_ff <= hcross_in;
      end
   end

endmodule

// ===== rtl/core/imu_upright_orientation_classifier.sv =====
`timescale 1ns / 1ps
// Upright orientation classifier, top level.
// The mode settle and the three squares are one combinational pass between the input register
// and the result register. Throughput: one beat per cycle while rsp_tready is high.
// Reset (synchronous): mode init, times, held sample values and flags cleared, registers to
// their defaults, both pipeline registers empty. No clearing pass; ready right after reset.
// Depends on imuc_pkg, imuc_csr, imuc_feature, imuc_core.
module imu_upright_orientation_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   // now_us[31:0], link_ok[32], accel_x[48:33], accel_y[64:49], accel_z[80:65],
   // gyro_x[96:81], gyro_y[112:97], gyro_z[128:113], zero fill above
   input  logic [imuc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // read_ok
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // mode[2:0], orientation_known[3], yaw_rate[19:4], sample_taken[20], read_failed[21],
   // rate_sum[38:22], accel_norm[59:39], cross_norm[80:60], zero fill above
   output logic [imuc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [imuc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [imuc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   imuc_pkg::cfg_type    cfg;
   imuc_pkg::item_type   in_ff, in_in;
   imuc_pkg::feat_type   feat;
   imuc_pkg::result_type result, out_ff, out_in;
   logic in_valid_ff, in_valid_in, out_valid_ff, out_valid_in;
   logic advance, req_beat;

   assign csr_ready = 1'b1;

   imuc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // input stage moves into the result register when that one is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_in = in_ff;
      if (req_beat) begin
         in_in.now_us  = req_tdata[31:0];
         in_in.link_ok = req_tdata[32];
         in_in.read_ok = req_tuser;
         in_in.accel_x = req_tdata[48:33];
         in_in.accel_y = req_tdata[64:49];
         in_in.accel_z = req_tdata[80:65];
         in_in.gyro_x  = req_tdata[96:81];
         in_in.gyro_y  = req_tdata[112:97];
         in_in.gyro_z  = req_tdata[128:113];
      end
      in_valid_in  = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_in       = advance ? result : out_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   imuc_feature u_feature (
      .item (in_ff),
      .cfg  (cfg),
      .feat (feat)
   );

   imuc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_ff),
      .feat   (feat),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.cross_norm, out_ff.accel_norm, out_ff.rate_sum,
                        out_ff.read_failed, out_ff.sample_taken, out_ff.yaw_rate,
                        out_ff.orientation_known, out_ff.mode};

   // a new beat never lands on an input stage that is not moving on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> (!in_valid_ff || advance))
      else $error("request beat overwrote a pending item");

   // init is left on the first processed beat
   a_init_left: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.mode != imuc_pkg::MODE_INIT))
      else $error("result reports init mode");

   a_known_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.orientation_known ==
                        ((out_ff.mode == imuc_pkg::MODE_UPRIGHT) ||
                         (out_ff.mode == imuc_pkg::MODE_NOT_UPRIGHT))))
      else $error("orientation_known disagrees with mode");

   // a failed read forces yaw to zero; mode settles before the sample, so it may still be known
   a_failed_yaw: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.read_failed) |-> (out_ff.yaw_rate == 16'd0))
      else $error("failed read with nonzero yaw");

endmodule

// ===== dv/imu_upright_orientation_classifier_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for imu_upright_orientation_classifier: directed corner items, then
// random update streams over several register settings and idle patterns, predicted in a class.
// Depends on imuc_pkg and the classifier RTL only.
module imu_upright_orientation_classifier_tb;
   import imuc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 4'd15;

   // Tracks mode, held sample values and registers; predicts one report per update beat.
   class upright_tracker;
      cfg_type     regs;
      logic [2:0]  mode_q;
      logic [31:0] mode_since;
      logic [31:0] last_sample;
      bit          failed;
      logic [15:0] ax_h, az_h, gz_h;
      int          rate_h, norm_h, cross_h;
      result_type  pending_reports[$];
      int          fails;

      function new();
         regs.sample_period_us      = RST_SAMPLE_PERIOD;
         regs.stationary_rate_limit = RST_STATIONARY_RATE;
         regs.upright_cross_limit   = RST_UPRIGHT_CROSS;
         regs.min_valid_cross       = RST_MIN_VALID_CROSS;
         regs.max_valid_cross       = RST_MAX_VALID_CROSS;
         regs.max_accel_norm        = RST_MAX_ACCEL_NORM;
         regs.x_tilt_threshold      = RST_X_TILT_THRESHOLD;
         regs.z_up_threshold        = RST_Z_UP_THRESHOLD;
         mode_q      = MODE_INIT;
         mode_since  = '0;
         last_sample = '0;
         failed      = 0;
         ax_h = '0; az_h = '0; gz_h = '0;
         rate_h = 0; norm_h = 0; cross_h = 0;
         fails = 0;
      endfunction

      function int sx(logic [15:0] v);
         int r;
         r = $signed(v);
         return r;
      endfunction

      function int abs16(logic [15:0] v);
         int r;
         r = sx(v);
         return (r < 0) ? -r : r;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_SAMPLE_PERIOD:    regs.sample_period_us      = d[30:0];
            REG_STATIONARY_RATE:  regs.stationary_rate_limit = d[17:0];
            REG_UPRIGHT_CROSS:    regs.upright_cross_limit   = d[15:0];
            REG_MIN_VALID_CROSS:  regs.min_valid_cross       = d[15:0];
            REG_MAX_VALID_CROSS:  regs.max_valid_cross       = d[15:0];
            REG_MAX_ACCEL_NORM:   regs.max_accel_norm        = d[15:0];
            REG_X_TILT_THRESHOLD: regs.x_tilt_threshold      = d[15:0];
            REG_Z_UP_THRESHOLD:   regs.z_up_threshold        = d[15:0];
            default: ;
         endcase
      endfunction

      function bit still();
         return !failed && rate_h < int'({14'd0, regs.stationary_rate_limit}) &&
                norm_h < sx(regs.max_accel_norm);
      endfunction

      function bit upright_ok();
         return still() && cross_h < sx(regs.upright_cross_limit) &&
                sx(az_h) > sx(regs.z_up_threshold);
      endfunction

      function bit tilted_ok();
         if (upright_ok() || !still())
            return 0;
         return cross_h > sx(regs.min_valid_cross) && cross_h < sx(regs.max_valid_cross) &&
                abs16(ax_h) > sx(regs.x_tilt_threshold);
      endfunction

      // one transition of the mode machine from the held values
      function logic [2:0] predict_mode(logic [31:0] now, bit link);
         logic [31:0] dt;
         dt = now - mode_since;
         case (mode_q)
            MODE_INIT: return MODE_SAFE;
            MODE_SAFE: begin
               if (dt > SAFE_MIN_TIME_US && link) return MODE_UNKNOWN;
            end
            MODE_UNKNOWN: begin
               if (!link) return MODE_SAFE;
               else if (upright_ok()) return MODE_UPRIGHT;
               else if (tilted_ok()) return MODE_NOT_UPRIGHT;
            end
            MODE_UPRIGHT: begin
               if (!link) return MODE_SAFE;
               else if (failed) return MODE_UNKNOWN;
               else if (tilted_ok()) return MODE_NOT_UPRIGHT;
               else if (!upright_ok()) return MODE_UNKNOWN;
            end
            MODE_NOT_UPRIGHT: begin
               if (!link) return MODE_SAFE;
               else if (failed) return MODE_UNKNOWN;
               else if (upright_ok()) return MODE_UPRIGHT;
               else if (!tilted_ok()) return MODE_UNKNOWN;
            end
            default: ;
         endcase
         return mode_q;
      endfunction

      function void take_update(item_type it);
         int          pass;
         logic [2:0]  nxt;
         bit          taken;
         int          sq_x, sq_y, sq_z;
         result_type  r;
         // settle first, on the values held from the previous sample
         for (pass = 0; pass < 8; pass++) begin
            nxt = predict_mode(it.now_us, it.link_ok);
            if (nxt == mode_q)
               break;
            mode_q     = nxt;
            mode_since = it.now_us;
         end
         taken = (it.now_us - last_sample) >= {1'b0, regs.sample_period_us};
         if (taken) begin
            last_sample = it.now_us;
            if (!it.read_ok) begin
               failed = 1;
            end else begin
               failed = 0;
               ax_h   = it.accel_x;
               az_h   = it.accel_z;
               gz_h   = it.gyro_z;
               sq_x   = (sx(it.accel_x) * sx(it.accel_x)) / 2048;
               sq_y   = (sx(it.accel_y) * sx(it.accel_y)) / 2048;
               sq_z   = (sx(it.accel_z) * sx(it.accel_z)) / 2048;
               rate_h = abs16(it.gyro_x) + abs16(it.gyro_y) + abs16(it.gyro_z);
               norm_h = sq_x + sq_y + sq_z;
               if (still())
                  cross_h = sq_y + sq_x;
            end
         end
         r.mode              = mode_q;
         r.orientation_known = (mode_q == MODE_UPRIGHT) || (mode_q == MODE_NOT_UPRIGHT);
         r.yaw_rate          = failed ? 16'd0 : gz_h;
         r.sample_taken      = taken;
         r.read_failed       = failed;
         r.rate_sum          = 17'(rate_h);
         r.accel_norm        = 21'(norm_h);
         r.cross_norm        = 21'(cross_h);
         pending_reports.push_back(r);
      endfunction

      function void field_check(string name, int e, int a);
         if (e != a) begin
            fails++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, a);
         end
      endfunction

      function void check_report(logic [RSP_DATA_W-1:0] d);
         result_type e;
         if (pending_reports.size() == 0) begin
            fails++;
            $display("%0t: report beat with nothing expected: expected none, got %h", $time, d);
            return;
         end
         e = pending_reports.pop_front();
         field_check("mode", e.mode, d[2:0]);
         field_check("orientation_known", e.orientation_known, d[3]);
         field_check("yaw_rate", e.yaw_rate, d[19:4]);
         field_check("sample_taken", e.sample_taken, d[20]);
         field_check("read_failed", e.read_failed, d[21]);
         field_check("rate_sum", e.rate_sum, d[38:22]);
         field_check("accel_norm", e.accel_norm, d[59:39]);
         field_check("cross_norm", e.cross_norm, d[80:60]);
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    req_tuser;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   upright_tracker tracker;
   int unsigned    send_idle_pct;
   int unsigned    recv_idle_pct;
   int             long_hold_cycles;
   logic [31:0]    stamp;

   imu_upright_orientation_classifier dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // accepted beats, sampled at the rising edge
   always @(posedge clock) begin : monitor
      item_type got;
      if (!reset) begin
         if (csr_valid && csr_ready)
            tracker.write_reg(csr_index, csr_wdata);
         if (rsp_tvalid && rsp_tready)
            tracker.check_report(rsp_tdata);
         if (req_tvalid && req_tready) begin
            got.now_us  = req_tdata[31:0];
            got.link_ok = req_tdata[32];
            got.read_ok = req_tuser;
            got.accel_x = req_tdata[48:33];
            got.accel_y = req_tdata[64:49];
            got.accel_z = req_tdata[80:65];
            got.gyro_x  = req_tdata[96:81];
            got.gyro_y  = req_tdata[112:97];
            got.gyro_z  = req_tdata[128:113];
            tracker.take_update(got);
         end
      end
   end

   // receiver: random stalls, plus an occasional long hold-off on request
   initial begin : receiver
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            for (n = 0; n < long_hold_cycles; n++)
               @(negedge clock);
            long_hold_cycles = 0;
         end
         rsp_tready = !reset && ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic int srange(int m);
      return int'($urandom_range(2 * m, 0)) - m;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(3, 0))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after the beat
   task automatic send_item(item_type it);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {7'd0, it.gyro_z, it.gyro_y, it.gyro_x, it.accel_z, it.accel_y,
                    it.accel_x, it.link_ok, it.now_us};
      req_tuser  = it.read_ok;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic put(logic [31:0] now, bit link, bit rd, int ax, int ay, int az,
                      int gx, int gy, int gz);
      item_type it;
      it.now_us  = now;
      it.link_ok = link;
      it.read_ok = rd;
      it.accel_x = 16'(ax);
      it.accel_y = 16'(ay);
      it.accel_z = 16'(az);
      it.gyro_x  = 16'(gx);
      it.gyro_y  = 16'(gy);
      it.gyro_z  = 16'(gz);
      stamp = now;
      send_item(it);
   endtask

   // mostly plausible upright / tilted / moving samples, some noise and extremes
   task automatic random_update(logic [31:0] period);
      int unsigned r;
      int          a [6];
      int          i;
      r = $urandom_range(99, 0);
      if (r < 3)
         stamp = $urandom();
      else if (r < 13)
         stamp = stamp + $urandom_range(1200000, 400000);
      else if (r < 55)
         stamp = stamp + period + $urandom_range(period / 2, 0);
      else
         stamp = stamp + $urandom_range(period, 0);
      r = $urandom_range(99, 0);
      if (r < 35 || (r >= 65 && r < 75)) begin
         a[0] = srange(600);
         a[1] = srange(600);
         a[2] = $urandom_range(2300, 2029);
         for (i = 3; i < 6; i++)
            a[i] = (r < 35) ? srange(60) : srange(3000);
      end else if (r < 65) begin
         a[0] = $urandom_range(2150, 1300);
         if ($urandom_range(1, 0)) a[0] = -a[0];
         a[1] = srange(300);
         a[2] = srange(1200);
         for (i = 3; i < 6; i++)
            a[i] = srange(60);
      end else if (r < 90) begin
         for (i = 0; i < 6; i++)
            a[i] = $urandom_range(65535, 0);
      end else begin
         for (i = 0; i < 6; i++)
            a[i] = pick_extreme();
      end
      put(stamp, $urandom_range(99, 0) < 96, $urandom_range(99, 0) < 92,
          a[0], a[1], a[2], a[3], a[4], a[5]);
   endtask

   // hold the sender until every report is back
   task automatic drain();
      req_tvalid = 1'b0;
      while (tracker.pending_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, int val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = 32'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(int period, int rate, int up, int minc, int maxc, int maxn,
                            int xt, int zu);
      drain();
      csr_put(REG_SAMPLE_PERIOD, period);
      csr_put(REG_STATIONARY_RATE, rate);
      csr_put(REG_UPRIGHT_CROSS, up);
      csr_put(REG_MIN_VALID_CROSS, minc);
      csr_put(REG_MAX_VALID_CROSS, maxc);
      csr_put(REG_MAX_ACCEL_NORM, maxn);
      csr_put(REG_X_TILT_THRESHOLD, xt);
      csr_put(REG_Z_UP_THRESHOLD, zu);
      csr_valid = 1'b0;
   endtask

   initial begin
      int k;
      clock            = 1'b0;
      reset            = 1'b1;
      req_tdata        = '0;
      req_tuser        = 1'b0;
      req_tvalid       = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      stamp            = '0;
      long_hold_cycles = 0;
      send_idle_pct    = 7;
      recv_idle_pct    = 82;
      tracker          = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset register values
      put(32'd0,       1, 1, 0, 0, 0, 0, 0, 0);            // init to safe
      put(32'd50000,   1, 1, 0, 0, 2100, 0, 0, 0);         // period not yet elapsed
      put(32'd100000,  1, 1, 0, 0, 2100, 0, 0, 5);         // exactly one period
      put(32'd1000000, 1, 1, 100, -100, 2100, 3, -3, 7);   // safe time not exceeded
      put(32'd1000001, 0, 1, 0, 0, 2100, 0, 0, 0);         // link down holds safe
      put(32'd1000002, 1, 1, 0, 0, 2100, 0, 0, 0);         // safe->unknown->upright
      put(32'd1200000, 1, 0, 0, 0, 0, 0, 0, 0);            // failed read
      put(32'd1200001, 1, 1, 0, 0, 0, 0, 0, 0);            // failed flag drops upright
      put(32'd1300001, 1, 1, -2000, 50, 1000, 10, -10, 20); // tilted sample
      put(32'd1300002, 1, 1, 0, 0, 0, 0, 0, 0);            // unknown -> not upright
      put(32'd1400002, 1, 1, -32768, -32768, -32768, -32768, -32768, -32768);
      put(32'd1400003, 1, 1, 0, 0, 0, 0, 0, 0);
      put(32'd1500003, 1, 1, 32767, 32767, 32767, 32767, 32767, 32767);
      put(32'd1600003, 1, 1, 0, 0, 2100, 100, 100, 0);     // rate sum equal to the limit
      put(32'd1600004, 0, 1, 0, 0, 0, 0, 0, 0);            // link loss to safe
      put(32'hFFFF_FFF0, 1, 1, 1229, 0, 2100, 0, 0, -1);   // near wrap, tilt at threshold
      put(32'h0000_0010, 1, 1, 0, 0, 2100, 0, 0, 0);       // across wrap, too soon
      put(32'h0003_0000, 1, 1, 0, 0, 2029, 0, 0, -5);      // z just above threshold
      put(32'h0003_0001, 1, 1, 0, 0, 0, 0, 0, 0);
      put(32'h0005_0000, 1, 1, 1830, 0, 0, 0, 0, 0);       // cross inside the valid band
      put(32'h0005_0001, 1, 1, 0, 0, 0, 0, 0, 0);

      configure(1000, 200, 410, 820, 2458, 3584, 1229, 2028);
      for (k = 0; k < 650; k++)
         random_update(32'd1000);

      send_idle_pct = 82;
      recv_idle_pct = 7;
      configure(0, 262143, 32767, -32768, 32767, 32767, -32768, -32768);
      for (k = 0; k < 600; k++)
         random_update(32'd0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(32'h7FFF_FFFF, 0, -32768, 32767, -32768, -32768, 32767, 32767);
      csr_put(CSR_UNUSED_INDEX, 32'h1234_5678);            // no such register
      csr_valid = 1'b0;
      for (k = 0; k < 150; k++)
         random_update(32'h7FFF_FFFF);

      configure(2500, 500, 600, 700, 3000, 4000, 1000, 1800);
      for (k = 0; k < 450; k++) begin
         if (k == 100)
            long_hold_cycles = 400;
         if (k == 300)
            drain();
         random_update(32'd2500);
      end

      drain();
      repeat (6) @(negedge clock);
      if (tracker.fails == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
